@@ src/wav_chunk_parser_macros.svh @@
// assertion macros of the wav chunk parser checker
`ifndef WAV_CHUNK_PARSER_MACROS_SVH
`define WAV_CHUNK_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define WCP_ASSERT_HOLD(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wcp check failed");

// next-cycle implication, sampled on clk, off during reset
`define WCP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wcp check failed");

`endif

@@ src/wcp_pkg.sv @@
// types and constants of the wav chunk parser
package wcp_pkg;

	typedef enum logic [2:0] {
		PH_RIFF  = 3'd0,
		PH_HDR   = 3'd1,
		PH_BODY  = 3'd2,
		PH_DATA  = 3'd3,
		PH_DONE  = 3'd4,
		PH_EMPTY = 3'd5
	} phase_t;

	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_FORMAT = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
	localparam logic [1:0] STATUS_NO_DATA   = 2'd2;

	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;
	localparam logic [3:0]  RIFF_LEN = 4'd12;
	localparam logic [3:0]  HDR_LEN  = 4'd8;
	localparam logic [15:0] BITS_16  = 16'd16;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [31:0] rate_hz;
		logic [15:0] channel_count;
		logic        sixteen_bit;
		logic [1:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]       count;
		result_t [1:0]    items;
	} push_t;

endpackage

@@ src/wcp_if.sv @@
// request channels of the wav chunk parser
interface wcp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_file;

	modport source (output valid, output in_byte, output end_of_file, input ready);
	modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

interface wcp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [31:0] rate_hz;
	logic [15:0] channel_count;
	logic        sixteen_bit;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, output kind, output data_byte, output rate_hz,
		output channel_count, output sixteen_bit, output status, output last, input ready);
	modport sink (input valid, input kind, input data_byte, input rate_hz,
		input channel_count, input sixteen_bit, input status, input last, output ready);
endinterface

@@ src/wcp_result_queue.sv @@
// small result queue taking up to two results a cycle and giving one
module wcp_result_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  wcp_pkg::push_t   push,
	output logic             room,
	output logic             head_valid,
	output wcp_pkg::result_t head,
	input  logic             head_ready
);

	wcp_pkg::result_t mem_q [wcp_pkg::QUEUE_DEPTH];
	logic [wcp_pkg::PTR_W-1:0] wr_q;
	logic [wcp_pkg::PTR_W-1:0] rd_q;
	logic [wcp_pkg::CNT_W-1:0] cnt_q;
	logic                      pop;

	assign pop        = head_valid && head_ready;
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];
	assign room       = cnt_q <= wcp_pkg::CNT_W'(wcp_pkg::QUEUE_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.items[0];
		end
		if (push.count == 2'd2) begin
			mem_q[wcp_pkg::PTR_W'(wr_q + 1'b1)] <= push.items[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + wcp_pkg::PTR_W'(push.count);
			rd_q  <= rd_q + wcp_pkg::PTR_W'(pop);
			cnt_q <= cnt_q + wcp_pkg::CNT_W'(push.count) - wcp_pkg::CNT_W'(pop);
		end
	end

endmodule

@@ src/wav_chunk_parser.sv @@
// wav chunk parser: walks a riff/wav byte stream and emits format records and data bytes
//
// stream carries one byte of the file per request, end_of_file set on the final byte.
// result carries one result per request: a data chunk byte (kind 0), a format record
// from each fmt chunk (kind 1) or an end report (kind 2) with status ok (empty data
// chunk), truncated or no data chunk; last marks the final result of a file.
// the first 12 bytes are skipped unchecked, then chunks are walked by their headers;
// after the last data byte the rest of the file is ignored.
// throughput: one byte per cycle while stream.ready is high; each byte is parsed in the
// cycle it is accepted and its zero, one or two results land in a four-entry
// result queue, whose head is shown on result in order.
// stream.ready is high while the queue has room for two more results, so it only
// drops once the receiver has stalled with three or more results waiting; a stalled
// result holds its payload until taken.
// reset puts the parser at the start of the riff header with an empty queue; the
// parser also returns there after every end_of_file byte, ready for the next file.
module wav_chunk_parser (
	input  logic       clk,
	input  logic       arst_n,
	wcp_in_if.sink     stream,
	wcp_out_if.source  result
);

	// parser state
	wcp_pkg::phase_t phase_q, phase_d, phase_step;
	logic [3:0]  bc_q, bc_d;           // byte index inside riff header or chunk header
	logic [31:0] tag_q, tag_d;
	logic [31:0] len_q, len_d;
	logic [32:0] rem_q, rem_d;         // body bytes left, pad byte included outside data chunks
	logic [31:0] fmt_left_q, fmt_left_d; // real fmt body bytes left, pad excluded
	logic [4:0]  off_q, off_d;         // body offset, saturates past the last field
	logic [31:0] rate_q, rate_d;
	logic [15:0] chan_q, chan_d;
	logic [15:0] bits_q, bits_d;

	logic        accept;
	logic        eof;
	logic [7:0]  b;
	logic        hdr_done;

	wcp_pkg::push_t   push;
	wcp_pkg::result_t head;
	logic             room;

	assign accept = stream.valid && stream.ready;
	assign eof    = stream.end_of_file;
	assign b      = stream.in_byte;
	assign stream.ready = room;
	assign hdr_done = accept && (phase_q == wcp_pkg::PH_HDR) && (bc_q == wcp_pkg::HDR_LEN - 4'd1);

	// next state
	always_comb begin
		phase_step = phase_q;
		bc_d       = bc_q;
		tag_d      = tag_q;
		len_d      = len_q;
		rem_d      = rem_q;
		fmt_left_d = fmt_left_q;
		off_d      = off_q;
		rate_d     = rate_q;
		chan_d     = chan_q;
		bits_d     = bits_q;
		if (accept) begin
			case (phase_q)
				wcp_pkg::PH_HDR: begin
					if (bc_q < 4'd4) begin
						tag_d = {tag_q[23:0], b};
						if (bc_q == 4'd0) begin
							len_d = '0;
						end
					end else begin
						len_d[8*bc_q[1:0] +: 8] = b;
					end
					bc_d = bc_q + 4'd1;
					if (bc_q == wcp_pkg::HDR_LEN - 4'd1) begin
						bc_d = '0;
						if (tag_q == wcp_pkg::TAG_DATA) begin
							if (len_d == '0) begin
								phase_step = wcp_pkg::PH_EMPTY;
							end else begin
								rem_d      = {1'b0, len_d};
								phase_step = wcp_pkg::PH_DATA;
							end
						end else begin
							// odd body is followed by one pad byte
							rem_d      = {1'b0, len_d} + {32'd0, len_d[0]};
							fmt_left_d = len_d;
							off_d      = '0;
							if (tag_q == wcp_pkg::TAG_FMT) begin
								rate_d = '0;
								chan_d = '0;
								bits_d = '0;
							end
							phase_step = (len_d != '0) ? wcp_pkg::PH_BODY : wcp_pkg::PH_HDR;
						end
					end
				end
				wcp_pkg::PH_BODY: begin
					if (tag_q == wcp_pkg::TAG_FMT && fmt_left_q != '0) begin
						case (off_q)
							5'd2: chan_d[7:0]  = b;
							5'd3: chan_d[15:8] = b;
							5'd4, 5'd5, 5'd6, 5'd7: rate_d[8*off_q[1:0] +: 8] = b;
							5'd14: bits_d[7:0]  = b;
							5'd15: bits_d[15:8] = b;
							default: ;
						endcase
						fmt_left_d = fmt_left_q - 32'd1;
					end
					if (off_q != 5'd16) begin
						off_d = off_q + 5'd1;
					end
					rem_d = rem_q - 33'd1;
					if (rem_q == 33'd1) begin
						phase_step = wcp_pkg::PH_HDR;
					end
				end
				wcp_pkg::PH_DATA: begin
					rem_d = rem_q - 33'd1;
					if (rem_q == 33'd1) begin
						phase_step = wcp_pkg::PH_DONE;
					end
				end
				wcp_pkg::PH_DONE, wcp_pkg::PH_EMPTY: ;
				default: begin
					// riff header skip, unused codes behave the same
					bc_d = bc_q + 4'd1;
					if (bc_q >= wcp_pkg::RIFF_LEN - 4'd1) begin
						bc_d       = '0;
						phase_step = wcp_pkg::PH_HDR;
					end
				end
			endcase
		end
		phase_d = phase_step;
		if (accept && eof) begin
			phase_d = wcp_pkg::PH_RIFF;
			bc_d    = '0;
		end
	end

	// results of the accepted byte, in order: step result, partial format, end report
	always_comb begin
		wcp_pkg::result_t step_r;
		wcp_pkg::result_t fmt_r;
		wcp_pkg::result_t end_r;
		logic             step_v;
		logic             efmt_v;
		logic             end_v;
		logic [1:0]       n;

		fmt_r               = '0;
		fmt_r.kind          = wcp_pkg::KIND_FORMAT;
		fmt_r.rate_hz       = rate_d;
		fmt_r.channel_count = chan_d;
		fmt_r.sixteen_bit   = bits_d == wcp_pkg::BITS_16;

		step_r = fmt_r;
		step_v = 1'b0;
		if (hdr_done && tag_q == wcp_pkg::TAG_FMT && len_d == '0) begin
			// empty fmt body: record right after the header
			step_v = 1'b1;
		end
		if (accept && phase_q == wcp_pkg::PH_BODY && tag_q == wcp_pkg::TAG_FMT &&
				fmt_left_q == 32'd1) begin
			step_v = 1'b1;
		end
		if (accept && phase_q == wcp_pkg::PH_DATA) begin
			step_v           = 1'b1;
			step_r           = '0;
			step_r.kind      = wcp_pkg::KIND_DATA;
			step_r.data_byte = b;
			step_r.last      = rem_q == 33'd1;
		end

		efmt_v = accept && eof && phase_step == wcp_pkg::PH_BODY &&
			tag_q == wcp_pkg::TAG_FMT && fmt_left_d != '0;

		end_r      = '0;
		end_r.kind = wcp_pkg::KIND_END;
		end_r.last = 1'b1;
		end_v      = accept && eof && phase_step != wcp_pkg::PH_DONE;
		case (phase_step)
			wcp_pkg::PH_DATA:  end_r.status = wcp_pkg::STATUS_TRUNCATED;
			wcp_pkg::PH_EMPTY: end_r.status = wcp_pkg::STATUS_OK;
			default:           end_r.status = wcp_pkg::STATUS_NO_DATA;
		endcase

		push = '0;
		n    = 2'd0;
		if (step_v) begin
			push.items[0] = step_r;
			n             = 2'd1;
		end
		if (efmt_v) begin
			push.items[n[0]] = fmt_r;
			n                = n + 2'd1;
		end
		if (end_v) begin
			push.items[n[0]] = end_r;
			n                = n + 2'd1;
		end
		push.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wcp_pkg::PH_RIFF;
			bc_q    <= '0;
		end else begin
			phase_q <= phase_d;
			bc_q    <= bc_d;
		end
	end

	// datapath registers, every read is preceded by a write in the parse order
	always_ff @(posedge clk) begin
		tag_q      <= tag_d;
		len_q      <= len_d;
		rem_q      <= rem_d;
		fmt_left_q <= fmt_left_d;
		off_q      <= off_d;
		rate_q     <= rate_d;
		chan_q     <= chan_d;
		bits_q     <= bits_d;
	end

	wcp_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (result.valid),
		.head       (head),
		.head_ready (result.ready)
	);

	assign result.kind          = head.kind;
	assign result.data_byte     = head.data_byte;
	assign result.rate_hz       = head.rate_hz;
	assign result.channel_count = head.channel_count;
	assign result.sixteen_bit   = head.sixteen_bit;
	assign result.status        = head.status;
	assign result.last          = head.last;

endmodule

@@ src/wcp_checker.sv @@
// port checker of the wav chunk parser and its bind
`include "wav_chunk_parser_macros.svh"

module wcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_kind,
	input logic [7:0]  out_data_byte,
	input logic [31:0] out_rate,
	input logic [15:0] out_chan,
	input logic        out_sixteen,
	input logic [1:0]  out_status,
	input logic        out_last
);

	// a stalled result holds
	`WCP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable({out_kind,
		out_data_byte, out_rate, out_chan, out_sixteen, out_status, out_last}))
	// an empty queue always takes a request
	`WCP_ASSERT_HOLD(a_empty_ready, !out_valid, in_ready)
	// an end report closes its file
	`WCP_ASSERT_HOLD(a_end_last, out_valid && out_kind == wcp_pkg::KIND_END, out_last)
	// a format record never closes a file
	`WCP_ASSERT_HOLD(a_fmt_open, out_valid && out_kind == wcp_pkg::KIND_FORMAT,
		!out_last && out_status == wcp_pkg::STATUS_OK)

endmodule

bind wav_chunk_parser wcp_checker u_wcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (stream.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_kind      (result.kind),
	.out_data_byte (result.data_byte),
	.out_rate      (result.rate_hz),
	.out_chan      (result.channel_count),
	.out_sixteen   (result.sixteen_bit),
	.out_status    (result.status),
	.out_last      (result.last)
);
